// ----- rtl/core/vnf_pkg.sv -----
// ----------------------------------------------------------------------------
// vnf_pkg: shared constants for the fractal value noise pipeline
// Hash constants, time gains, pipeline stage counts and default octave count.
// ----------------------------------------------------------------------------
package vnf_pkg;

  localparam int unsigned OCTAVE_COUNT_DEF = 3;

  localparam int TIME_GAIN_X = 45875;
  localparam int TIME_GAIN_Y = 19661;

  localparam logic [31:0] HASH_X   = 32'd374761393;
  localparam logic [31:0] HASH_Y   = 32'd668265263;
  localparam logic [31:0] HASH_ADD = 32'd1013904223;
  localparam logic [31:0] HASH_MUL = 32'd1274126177;

  localparam int unsigned TIME_W = 49;
  localparam int unsigned OCT_W = 52;
  localparam int unsigned OCT_STAGES = 7;
  localparam int unsigned DIV_STAGES = 4;
  localparam int unsigned NUM_STAGES = OCT_STAGES + DIV_STAGES + 4;

endpackage

// ----- rtl/core/vnf_if.sv -----
// ----------------------------------------------------------------------------
// vnf_if: stream channels of the value noise block
// Sample channel (point and time) and result channel (noise value).
// ----------------------------------------------------------------------------
interface vnf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;
  logic signed [31:0] time_value;

  modport source (output valid, output x_coord, output y_coord, output time_value,
                  input ready);
  modport sink (input valid, input x_coord, input y_coord, input time_value,
                output ready);
endinterface

interface vnf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink (input valid, input noise_value, output ready);
endinterface

// ----- rtl/core/vnf_octave.sv -----
// ----------------------------------------------------------------------------
// vnf_octave: one octave of lattice value noise
// Seven register stages: lattice point, hash multiplies, hash mixing,
// smoothstep weights, corner codes and the two blending passes.
// ----------------------------------------------------------------------------
module vnf_octave
  import vnf_pkg::*;
#(
  parameter int unsigned OCT_K = 0
) (
  input  logic                     clk,
  input  logic [OCT_STAGES-1:0]    en,
  input  logic signed [31:0]       x_coord,
  input  logic signed [31:0]       y_coord,
  input  logic signed [TIME_W-1:0] tx,
  input  logic signed [TIME_W-1:0] ty,
  output logic signed [OCT_W-1:0]  octave_value
);

  logic [63:0] cx;
  logic [63:0] cy;
  logic [31:0] ix;
  logic [31:0] iy;
  logic [15:0] fx;
  logic [15:0] fy;

  assign cx = (64'(x_coord) << (OCT_K + 16)) + 64'(tx);
  assign cy = (64'(y_coord) << (OCT_K + 16)) + 64'(ty);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ix <= cx[63:32];
      iy <= cy[63:32];
      fx <= cx[31:16];
      fy <= cy[31:16];
    end
  end

  logic [31:0] ax;
  logic [31:0] ay;
  logic [31:0] ffx;
  logic [31:0] ffy;
  logic [15:0] fx2;
  logic [15:0] fy2;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ax  <= ix * HASH_X;
      ay  <= iy * HASH_Y;
      ffx <= {16'd0, fx} * {16'd0, fx};
      ffy <= {16'd0, fy} * {16'd0, fy};
      fx2 <= fx;
      fy2 <= fy;
    end
  end

  logic [31:0] hsum [4];
  logic [31:0] hmix [4];
  logic [17:0] wx;
  logic [17:0] wy;
  logic [49:0] px;
  logic [49:0] py;
  logic [16:0] sx;
  logic [16:0] sy;

  always_comb begin
    hsum[0] = ax + ay + HASH_ADD;
    hsum[1] = hsum[0] + HASH_X;
    hsum[2] = hsum[0] + HASH_Y;
    hsum[3] = hsum[1] + HASH_Y;
    wx = 18'd196608 - {1'b0, fx2, 1'b0};
    wy = 18'd196608 - {1'b0, fy2, 1'b0};
    px = {18'd0, ffx} * {32'd0, wx};
    py = {18'd0, ffy} * {32'd0, wy};
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 4; i++) begin
        hmix[i] <= hsum[i] ^ 32'($signed(hsum[i]) >>> 13);
      end
      sx <= 17'((px + 50'h80000000) >> 32);
      sy <= 17'((py + 50'h80000000) >> 32);
    end
  end

  logic [31:0] hmul [4];
  logic [16:0] sx3;
  logic [16:0] sy3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 4; i++) begin
        hmul[i] <= hmix[i] * HASH_MUL;
      end
      sx3 <= sx;
      sy3 <= sy;
    end
  end

  logic signed [17:0] crn [4];
  logic [16:0] sx4;
  logic [16:0] sy4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < 4; i++) begin
        crn[i] <= $signed({1'b0, hmul[i][15:0] ^ hmul[i][31:16], 1'b0}) - 18'sd65535;
      end
      sx4 <= sx3;
      sy4 <= sy3;
    end
  end

  logic signed [18:0] dx0;
  logic signed [18:0] dx1;
  logic signed [36:0] r0w;
  logic signed [36:0] r1w;
  logic signed [36:0] r0;
  logic signed [36:0] r1;
  logic [16:0] sy5;

  always_comb begin
    dx0 = 19'(crn[1]) - 19'(crn[0]);
    dx1 = 19'(crn[3]) - 19'(crn[2]);
    r0w = (37'(crn[0]) <<< 16) + 37'(dx0) * 37'($signed({1'b0, sx4}));
    r1w = (37'(crn[2]) <<< 16) + 37'(dx1) * 37'($signed({1'b0, sx4}));
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      r0  <= r0w;
      r1  <= r1w;
      sy5 <= sy4;
    end
  end

  logic signed [37:0] dr;
  logic signed [OCT_W-1:0] ow;

  always_comb begin
    dr = 38'(r1) - 38'(r0);
    ow = (OCT_W'(r0) <<< 16) + OCT_W'(dr) * OCT_W'($signed({1'b0, sy5}));
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      octave_value <= ow;
    end
  end

endmodule

// ----- rtl/core/value_noise_fbm.sv -----
// ----------------------------------------------------------------------------
// value_noise_fbm: three-octave fractal value noise, Q16.16 in, Q1.15 out
// Octaves run side by side, then the weighted sum is normalized by a
// pipelined constant divider and saturated.
// ----------------------------------------------------------------------------
// Channel  Role    Payload
// sample   sink    x_coord, y_coord, time_value (signed Q16.16)
// result   source  noise_value (signed Q1.15)
//
// One sample is taken per cycle while sample.ready is high.
// The depth is set by the octave hash and blend stages and the four-stage
// divider. Reset clears only the valid bits. A stall holds each occupied
// stage that has only occupied stages after it, while the other stages keep
// moving and filling, so sample.ready drops only when all stages are full
// and the result is not taken.
// ----------------------------------------------------------------------------
module value_noise_fbm
  import vnf_pkg::*;
#(
  parameter int unsigned OCTAVE_COUNT = OCTAVE_COUNT_DEF
) (
  input  logic  clk,
  input  logic  rst,
  vnf_in_if.sink    sample,
  vnf_out_if.source result
);

  localparam int unsigned SUM_W = OCTAVE_COUNT + 50;
  localparam int unsigned DEN_W = OCTAVE_COUNT + 16;
  localparam int unsigned M_W = OCTAVE_COUNT + 33;
  localparam logic [DEN_W-1:0] DEN = DEN_W'(((2 ** OCTAVE_COUNT) - 1) * 65535);
  localparam int unsigned STG_SUM = OCT_STAGES + 1;
  localparam int unsigned STG_MAG = OCT_STAGES + 2;
  localparam int unsigned RCP_SH = OCTAVE_COUNT + 15;
  localparam int unsigned RCP_P = 24;
  localparam int unsigned RCP_W = 25;
  localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << (RCP_SH + RCP_P)) / 64'(DEN));
  localparam int unsigned QD_W = DEN_W + 16;

  logic [NUM_STAGES-1:0] v;
  logic [NUM_STAGES-1:0] en;

  always_comb begin
    en[NUM_STAGES-1] = !v[NUM_STAGES-1] || result.ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= sample.valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  assign sample.ready = en[0];

  logic signed [31:0] xr;
  logic signed [31:0] yr;
  logic signed [TIME_W-1:0] tx;
  logic signed [TIME_W-1:0] ty;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xr <= sample.x_coord;
      yr <= sample.y_coord;
      tx <= TIME_W'(sample.time_value) * TIME_W'(TIME_GAIN_X);
      ty <= TIME_W'(sample.time_value) * TIME_W'(TIME_GAIN_Y);
    end
  end

  logic signed [OCT_W-1:0] oct [OCTAVE_COUNT];

  for (genvar k = 0; k < OCTAVE_COUNT; k++) begin : g_oct
    vnf_octave #(
      .OCT_K (k)
    ) u_octave (
      .clk          (clk),
      .en           (en[OCT_STAGES:1]),
      .x_coord      (xr),
      .y_coord      (yr),
      .tx           (tx),
      .ty           (ty),
      .octave_value (oct[k])
    );
  end

  logic signed [SUM_W-1:0] acc;
  logic signed [SUM_W-1:0] sum;

  always_comb begin
    acc = '0;
    for (int k = 0; k < OCTAVE_COUNT; k++) begin
      acc = acc + (SUM_W'(oct[k]) <<< (OCTAVE_COUNT - 1 - k));
    end
  end

  always_ff @(posedge clk) begin
    if (en[STG_SUM]) begin
      sum <= acc;
    end
  end

  logic [SUM_W-1:0] mag;
  logic [M_W-1:0] rem0;
  logic [M_W-1:0] rem1;
  logic [M_W-1:0] rem2;
  logic [M_W-1:0] rem3;
  logic [15:0] est_q;
  logic [15:0] quo2;
  logic [15:0] quo3;
  logic [15:0] quo4;
  logic neg0;
  logic neg1;
  logic neg2;
  logic neg3;
  logic neg4;
  logic [16:0] n_hi;
  logic [RCP_W+16:0] qprod;
  logic [QD_W-1:0] qd;

  assign mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  always_ff @(posedge clk) begin
    if (en[STG_MAG]) begin
      rem0 <= M_W'((mag + (SUM_W'(DEN) << 16)) >> 17);
      neg0 <= sum[SUM_W-1];
    end
  end

  assign n_hi = rem0[RCP_SH+16:RCP_SH];
  assign qprod = (RCP_W + 17)'(n_hi) * (RCP_W + 17)'(RECIP);
  assign qd = QD_W'(est_q) * QD_W'(DEN);

  always_ff @(posedge clk) begin
    if (en[STG_MAG + 1]) begin
      est_q <= qprod[RCP_P+15:RCP_P];
      rem1  <= rem0;
      neg1  <= neg0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[STG_MAG + 2]) begin
      rem2 <= rem1 - M_W'(qd);
      quo2 <= est_q;
      neg2 <= neg1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[STG_MAG + 3]) begin
      if (rem2 >= M_W'(DEN)) begin
        rem3 <= rem2 - M_W'(DEN);
        quo3 <= quo2 + 16'd1;
      end else begin
        rem3 <= rem2;
        quo3 <= quo2;
      end
      neg3 <= neg2;
    end
  end

  always_ff @(posedge clk) begin
    if (en[STG_MAG + 4]) begin
      if (rem3 >= M_W'(DEN)) begin
        quo4 <= quo3 + 16'd1;
      end else begin
        quo4 <= quo3;
      end
      neg4 <= neg3;
    end
  end

  logic [15:0] qf;
  logic signed [15:0] noise_next;
  logic signed [15:0] noise;

  assign qf = quo4;

  always_comb begin
    if (neg4) begin
      noise_next = (qf > 16'd32768) ? 16'sh8000 : $signed(16'd0 - qf);
    end else begin
      noise_next = (qf > 16'd32767) ? 16'sh7FFF : $signed(qf);
    end
  end

  always_ff @(posedge clk) begin
    if (en[NUM_STAGES-1]) begin
      noise <= noise_next;
    end
  end

  assign result.valid = v[NUM_STAGES-1];
  assign result.noise_value = noise;

endmodule

// ----- rtl/core/vnf_check.sv -----
// ----------------------------------------------------------------------------
// vnf_check: port-level checks for value_noise_fbm
// Reset state, result hold under stall and the stall relation between sides.
// ----------------------------------------------------------------------------
module vnf_check (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] noise_value
);

  a_reset_state: assert property (@(posedge clk) rst |=> in_ready && !out_valid)
    else $error("pipeline not empty after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(noise_value))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("sample side stalled without a result stall");

  a_flow_through: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |-> in_ready)
    else $error("sample side stalled during a result transfer");

endmodule

bind value_noise_fbm vnf_check u_vnf_check (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (sample.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .noise_value (result.noise_value)
);

// ----- verif/value_noise_fbm_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_noise_fbm testbench: self-checking regression of the noise pipeline
// Samples are sent through the sample channel, an independent model computes
// the expected Q1.15 noise for each, and every result is compared in order.
// ----------------------------------------------------------------------------
module testbench;
  import vnf_pkg::*;

  localparam int OCTAVES = 3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic idle_enable = 1'b1;
  bit   failed = 1'b0;
  int   cycle_count = 0;

  vnf_in_if  sample();
  vnf_out_if result();

  value_noise_fbm #(.OCTAVE_COUNT(OCTAVES)) u_dut (
    .clk(clk), .rst(rst), .sample(sample), .result(result)
  );

  logic signed [15:0] expected_noise[$];

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] shift_right_signed(logic [31:0] v, int s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic longint corner_code(logic [31:0] ix, logic [31:0] iy);
    logic [31:0] h;
    h = ix * HASH_X + iy * HASH_Y + HASH_ADD;
    h = (h ^ shift_right_signed(h, 13)) * HASH_MUL;
    h = h ^ shift_right_signed(h, 16);
    return 2 * longint'(h[15:0]) - 65535;
  endfunction

  function automatic longint smooth_weight(logic [15:0] f);
    logic [63:0] p;
    p = 64'(f) * 64'(f) * (64'd196608 - 2 * 64'(f));
    return longint'((p + 64'h8000_0000) >> 32);
  endfunction

  function automatic longint octave_sum(longint x, longint y, longint t, int k);
    logic [63:0] cx, cy;
    logic [31:0] ix, iy;
    longint sx, sy, c00, c10, c01, c11, r0, r1;
    cx = (x <<< (k + 16)) + t * TIME_GAIN_X;
    cy = (y <<< (k + 16)) + t * TIME_GAIN_Y;
    ix = cx[63:32];
    iy = cy[63:32];
    sx = smooth_weight(cx[31:16]);
    sy = smooth_weight(cy[31:16]);
    c00 = corner_code(ix, iy);
    c10 = corner_code(ix + 1, iy);
    c01 = corner_code(ix, iy + 1);
    c11 = corner_code(ix + 1, iy + 1);
    r0 = c00 * 65536 + (c10 - c00) * sx;
    r1 = c01 * 65536 + (c11 - c01) * sx;
    return r0 * 65536 + (r1 - r0) * sy;
  endfunction

  function automatic logic signed [15:0] fbm_noise(logic signed [31:0] x,
                                                    logic signed [31:0] y,
                                                    logic signed [31:0] t);
    longint sum;
    logic [63:0] mag, den, q;
    sum = 0;
    for (int k = 0; k < OCTAVES; k++) begin
      sum += octave_sum(x, y, t, k) * (longint'(1) <<< (OCTAVES - 1 - k));
    end
    den = ((64'd1 << OCTAVES) - 1) * 64'd65535 * 64'd131072;
    mag = (sum < 0) ? -sum : sum;
    q = (mag + den / 2) / den;
    if (sum < 0) begin
      return (q > 32768) ? -16'sd32768 : -$signed(q[15:0]);
    end else begin
      return (q > 32767) ? 16'sd32767 : $signed(q[15:0]);
    end
  endfunction

  task automatic send_sample(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] t);
    int gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      sample.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample.valid <= 1'b1;
    sample.x_coord <= x;
    sample.y_coord <= y;
    sample.time_value <= t;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    expected_noise.push_back(fbm_noise(x, y, t));
  endtask

  task automatic drain_results();
    sample.valid <= 1'b0;
    @(posedge clk);
    while (expected_noise.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return $urandom_range(0, 1) ? 32'h7FFF_0000 + $urandom_range(0, 65535)
                                         : 32'h8000_0000 + $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic test_directed();
    logic signed [31:0] edges[6] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, -1,
                                     32'sh0001_0000, 32'sh0000_FFFF};
    for (int i = 0; i < 6; i++) begin
      send_sample(edges[i], edges[(i + 1) % 6], edges[(i + 2) % 6]);
    end
    send_sample(0, 0, 0);
    send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_sample(-1, -1, -1);
    send_sample(32'sh0000_8000, 32'sh0000_8000, 0);
    send_sample(32'sh0000_0001, 32'sh0000_0001, 32'sh0001_0000);
    send_sample(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh3333_3333);
    send_sample(32'shAAAA_AAAA, 32'sh5555_5555, 32'shCCCC_CCCC);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      send_sample(random_word(), random_word(), random_word());
    end
  endtask

  task automatic test_back_to_back(int count);
    idle_enable <= 1'b0;
    for (int i = 0; i < count; i++) begin
      send_sample($urandom, $urandom, $urandom);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      if (expected_noise.size() == 0) begin
        failed <= 1'b1;
        $display("%0t: unexpected result %0d", $time, result.noise_value);
      end else begin
        if (result.noise_value !== expected_noise[0]) begin
          failed <= 1'b1;
          $display("%0t: noise_value expected %0d actual %0d", $time,
                   expected_noise[0], result.noise_value);
        end
        void'(expected_noise.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b1;
    end else if (!idle_enable) begin
      result.ready <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      result.ready <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
      result.ready <= 1'b1;
    end else begin
      result.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("value_noise_fbm regression: fail");
      $finish;
    end
  end

  initial begin
    sample.valid = 1'b0;
    sample.x_coord = '0;
    sample.y_coord = '0;
    sample.time_value = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    drain_results();
    test_random(1200);
    drain_results();
    test_back_to_back(300);
    drain_results();
    repeat (NUM_STAGES + 10) @(posedge clk);
    if (!failed) begin
      $display("value_noise_fbm regression: pass");
    end else begin
      $display("value_noise_fbm regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/vnf_pkg.sv
rtl/core/vnf_if.sv
rtl/core/vnf_octave.sv
rtl/core/value_noise_fbm.sv
rtl/core/vnf_check.sv
verif/value_noise_fbm_tb.sv
